@@ src/tsq_pkg.sv @@
// ----------------------------------------------------------------------------
// tsq_pkg: shared definitions for the timestamp ordered packet queue
// Default sizes, command and status codes, and the control word that is
// broadcast to every cell of the sorted chain.
// ----------------------------------------------------------------------------
package tsq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 48;
    localparam int TAG_BITS_DEF    = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Operation applied to the whole chain at once.
    typedef struct packed {
        logic ins;
        logic rem;
    } tsq_ctl_t;

endpackage

@@ src/tsq_cell.sv @@
// ----------------------------------------------------------------------------
// tsq_cell: one slot of the sorted chain
// Holds one entry and decides each cycle whether to keep it, take the new
// entry, take the left neighbour's entry (insert) or the right one's (remove).
// ----------------------------------------------------------------------------
module tsq_cell #(
    parameter int TIME_BITS = 48,
    parameter int TAG_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tsq_pkg::tsq_ctl_t     ctl,
    input  logic [TIME_BITS-1:0]  ins_time,
    input  logic [TAG_BITS-1:0]   ins_tag,
    input  logic                  left_valid,
    input  logic                  left_place,
    input  logic [TIME_BITS-1:0]  left_time,
    input  logic [TAG_BITS-1:0]   left_tag,
    input  logic                  right_valid,
    input  logic [TIME_BITS-1:0]  right_time,
    input  logic [TAG_BITS-1:0]   right_tag,
    output logic                  place,
    output logic                  valid_reg,
    output logic [TIME_BITS-1:0]  time_reg,
    output logic [TAG_BITS-1:0]   tag_reg,
    output logic                  valid_next,
    output logic [TIME_BITS-1:0]  time_next,
    output logic [TAG_BITS-1:0]   tag_next
);
    import tsq_pkg::*;

    // The new entry belongs at or before this slot when the slot is empty or
    // holds a strictly later time, so equal times keep arrival order.
    assign place = !valid_reg || (time_reg > ins_time);

    always_comb begin
        valid_next = valid_reg;
        time_next  = time_reg;
        tag_next   = tag_reg;
        if (ctl.ins) begin
            valid_next = left_valid;
            if (place) begin
                if (left_place) begin
                    time_next = left_time;
                    tag_next  = left_tag;
                end else begin
                    time_next = ins_time;
                    tag_next  = ins_tag;
                end
            end
        end else if (ctl.rem) begin
            valid_next = right_valid;
            time_next  = right_time;
            tag_next   = right_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        time_reg <= time_next;
        tag_reg  <= tag_next;
    end

endmodule

@@ src/timestamp_ordered_packet_queue.sv @@
// ----------------------------------------------------------------------------
// timestamp_ordered_packet_queue: sorted queue of packet tags by send time
// A chain of QUEUE_DEPTH cells keeps the entries in ascending time order with
// the head in cell 0. Each beat inserts an entry or removes the head, unless
// the queue is full or empty, and yields one result beat describing it after.
//
//   Channel  | Direction | Handshake         | Payload
//   ---------+-----------+-------------------+--------------------------------
//   s_       | in        | s_valid / s_ready | cmd, send_time, packet_tag
//   m_       | out       | m_valid / m_ready | head_time, head_tag, is_empty,
//            |           |                   | entry_count, status
//
// One command beat is taken every cycle while s_ready is high; its result
// appears in the output register on the following cycle. Every cell compares
// its time with the new time in parallel, so compare and shift happen together.
// While a result waits, a new beat is still taken if m_ready is high in the
// same cycle; otherwise s_ready is low until the result is taken.
// Reset (aresetn low, synchronous) empties the queue.
// ----------------------------------------------------------------------------
module timestamp_ordered_packet_queue #(
    parameter int QUEUE_DEPTH = tsq_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = tsq_pkg::TIME_BITS_DEF,
    parameter int TAG_BITS    = tsq_pkg::TAG_BITS_DEF,
    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_cmd,
    input  logic [TIME_BITS-1:0]   s_send_time,
    input  logic [TAG_BITS-1:0]    s_packet_tag,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [TIME_BITS-1:0]   m_head_time,
    output logic [TAG_BITS-1:0]    m_head_tag,
    output logic                   m_is_empty,
    output logic [COUNT_BITS-1:0]  m_entry_count,
    output logic [1:0]             m_status
);
    import tsq_pkg::*;

    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(QUEUE_DEPTH);

    logic                   accept;
    logic                   full;
    logic                   empty;
    tsq_ctl_t               ctl;
    status_t                status_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;

    logic                   out_valid_reg;
    logic [TIME_BITS-1:0]   head_time_reg;
    logic [TAG_BITS-1:0]    head_tag_reg;
    logic                   is_empty_reg;
    logic [COUNT_BITS-1:0]  entry_count_reg;
    status_t                status_reg;

    // Per-cell wiring of the chain.
    logic [QUEUE_DEPTH-1:0] cell_place;
    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [TIME_BITS-1:0]   cell_time [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    cell_tag  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_valid_next;
    logic [TIME_BITS-1:0]   cell_time_next [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    cell_tag_next  [QUEUE_DEPTH];

    // The input side may advance whenever the output register is free or is
    // being emptied in this very cycle.
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign full  = (count_reg == FULL_COUNT);
    assign empty = (count_reg == '0);

    // A rejected insert or remove leaves the chain untouched.
    always_comb begin
        ctl.ins     = accept && (s_cmd == CMD_INSERT) && !full;
        ctl.rem     = accept && (s_cmd == CMD_REMOVE) && !empty;
        status_next = ST_OK;
        if (s_cmd == CMD_INSERT) begin
            if (full) begin
                status_next = ST_FULL;
            end
        end else begin
            if (empty) begin
                status_next = ST_EMPTY;
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.ins) begin
            count_next = count_reg + COUNT_BITS'(1);
        end else if (ctl.rem) begin
            count_next = count_reg - COUNT_BITS'(1);
        end
    end

    // The chain itself. Cell 0 sees an always-valid left neighbour that never
    // accepts the new entry, so it takes the new entry itself when the new
    // time sorts first. The last cell receives an empty slot on a remove.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic                 left_valid;
        logic                 left_place;
        logic [TIME_BITS-1:0] left_time;
        logic [TAG_BITS-1:0]  left_tag;
        logic                 right_valid;
        logic [TIME_BITS-1:0] right_time;
        logic [TAG_BITS-1:0]  right_tag;

        if (i == 0) begin : g_first
            assign left_valid = 1'b1;
            assign left_place = 1'b0;
            assign left_time  = '0;
            assign left_tag   = '0;
        end else begin : g_inner_left
            assign left_valid = cell_valid[i-1];
            assign left_place = cell_place[i-1];
            assign left_time  = cell_time[i-1];
            assign left_tag   = cell_tag[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign right_valid = 1'b0;
            assign right_time  = '0;
            assign right_tag   = '0;
        end else begin : g_inner_right
            assign right_valid = cell_valid[i+1];
            assign right_time  = cell_time[i+1];
            assign right_tag   = cell_tag[i+1];
        end

        tsq_cell #(
            .TIME_BITS (TIME_BITS),
            .TAG_BITS  (TAG_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .ins_time    (s_send_time),
            .ins_tag     (s_packet_tag),
            .left_valid  (left_valid),
            .left_place  (left_place),
            .left_time   (left_time),
            .left_tag    (left_tag),
            .right_valid (right_valid),
            .right_time  (right_time),
            .right_tag   (right_tag),
            .place       (cell_place[i]),
            .valid_reg   (cell_valid[i]),
            .time_reg    (cell_time[i]),
            .tag_reg     (cell_tag[i]),
            .valid_next  (cell_valid_next[i]),
            .time_next   (cell_time_next[i]),
            .tag_next    (cell_tag_next[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The result describes the queue after the beat, so it is taken from the
    // head cell's next value. An empty queue reports zeros in the head fields.
    always_ff @(posedge aclk) begin
        if (accept) begin
            head_time_reg   <= cell_valid_next[0] ? cell_time_next[0] : '0;
            head_tag_reg    <= cell_valid_next[0] ? cell_tag_next[0] : '0;
            is_empty_reg    <= (count_next == '0);
            entry_count_reg <= count_next;
            status_reg      <= status_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_head_time   = head_time_reg;
    assign m_head_tag    = head_tag_reg;
    assign m_is_empty    = is_empty_reg;
    assign m_entry_count = entry_count_reg;
    assign m_status      = status_reg;

    // The number of occupied cells always matches the entry counter.
    a_count_matches_cells : assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == count_reg)
        else $error("entry counter disagrees with occupied cells");

    // Neighbouring occupied cells are in ascending time order.
    for (genvar j = 0; j < QUEUE_DEPTH - 1; j++) begin : g_order_chk
        a_sorted : assert property (@(posedge aclk) disable iff (!aresetn)
            (cell_valid[j] && cell_valid[j+1]) |-> (cell_time[j] <= cell_time[j+1]))
            else $error("queue order broken between neighbouring cells");
    end

    // A dropped insert is only ever reported with a full queue.
    a_full_status : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_FULL)) |-> (m_entry_count == FULL_COUNT))
        else $error("full status reported on a queue that is not full");

    // The empty flag and the count of the result agree.
    a_empty_flag : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_empty == (m_entry_count == '0)))
        else $error("empty flag disagrees with entry count");

endmodule
